// ----- rtl/core/adsr_pkg.sv -----
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared widths, phase codes, register indexes and types for the ADSR
// envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

	localparam int LVL_W      = 31;
	localparam int BASE_W     = 32;
	localparam int PAIR_W     = 63;
	localparam int HOLD_LEN_W = 24;
	localparam int MODE_W     = 3;
	localparam int PH_W       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 63;

	localparam int HOLD_BITS_DEF = 24;

	localparam logic [LVL_W-1:0] LVL_MAX      = 31'h7FFF_FFFF;
	localparam logic [LVL_W-1:0] FREEZE_FLOOR = 31'd42949672;

	// phase codes
	localparam logic [PH_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PH_W-1:0] PH_ATTACK  = 3'd1;
	localparam logic [PH_W-1:0] PH_HOLD    = 3'd2;
	localparam logic [PH_W-1:0] PH_DECAY   = 3'd3;
	localparam logic [PH_W-1:0] PH_SUSTAIN = 3'd4;
	localparam logic [PH_W-1:0] PH_RELEASE = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FREEZE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd6;

	// mode bit positions
	localparam int MODE_LOOP    = 0;
	localparam int MODE_NR_ATK  = 1;
	localparam int MODE_NR_DCY  = 2;

	typedef struct packed {
		logic trigger;
		logic hold_gate;
		logic freeze_decay;
	} tick_t;

endpackage

// ----- rtl/core/adsr_curve.sv -----
// ----------------------------------------------------------------------------
// adsr_curve
// One curve step: base + (level * coef) >> 31, clamped to 0..full scale.
// ----------------------------------------------------------------------------
module adsr_curve import adsr_pkg::*; (
	input  logic [PAIR_W-1:0] pair,
	input  logic [LVL_W-1:0]  level_in,
	output logic [LVL_W-1:0]  level_out
);

	localparam int PROD_W = 2 * LVL_W;
	localparam int SUM_W  = LVL_W + 3;

	logic [PROD_W-1:0]       prod;
	logic signed [BASE_W-1:0] base;
	logic signed [SUM_W-1:0]  hi_ext;
	logic signed [SUM_W-1:0]  base_ext;
	logic signed [SUM_W-1:0]  sum;

	assign prod     = PROD_W'(level_in) * PROD_W'(pair[LVL_W-1:0]);
	assign base     = signed'(pair[PAIR_W-1:LVL_W]);
	assign hi_ext   = signed'(SUM_W'(prod[PROD_W-1:LVL_W]));
	assign base_ext = SUM_W'(base);
	assign sum      = hi_ext + base_ext;

	always_comb begin
		if (sum[SUM_W-1]) begin
			level_out = '0;
		end else if (sum[SUM_W-2:LVL_W] != '0) begin
			level_out = LVL_MAX;
		end else begin
			level_out = sum[LVL_W-1:0];
		end
	end

endmodule

// ----- rtl/core/adsr_envelope_generator.sv -----
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Exponential ADSR envelope with hold, looping, retrigger and decay freeze.
// ----------------------------------------------------------------------------
// One tick is taken per clock cycle unless the output stalls. An accepted tick
// lands in the input register (tick_s1); when it advances, the envelope state
// takes one multiply-add-clamp step and the new level and phase are
// registered in level_q and phase_q, which drive the output. The loop
// through the state registers and the single 31x31 curve multiplier sets this
// rate. Configuration writes are taken every cycle and apply to later ticks.
// ----------------------------------------------------------------------------
module adsr_envelope_generator import adsr_pkg::*; #(
	parameter int HOLD_BITS = HOLD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  trigger,
	input  logic                  hold_gate,
	input  logic                  freeze_decay,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LVL_W-1:0]      level,
	output logic [PH_W-1:0]       phase,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CMP_W = (HOLD_BITS > HOLD_LEN_W) ? HOLD_BITS : HOLD_LEN_W;

	// configuration
	logic [PAIR_W-1:0]     attack_pair_q;
	logic [PAIR_W-1:0]     decay_pair_q;
	logic [PAIR_W-1:0]     release_pair_q;
	logic [PAIR_W-1:0]     freeze_pair_q;
	logic [LVL_W-1:0]      sustain_q;
	logic [HOLD_LEN_W-1:0] hold_len_q;
	logic [MODE_W-1:0]     mode_q;

	// input stage
	tick_t tick_s1;
	logic  valid_s1;

	// envelope state, also the result register
	logic [LVL_W-1:0]     level_q;
	logic [PH_W-1:0]      phase_q;
	logic [HOLD_BITS-1:0] hold_cnt_q;
	logic                 gate_seen_q;
	logic                 out_valid_q;

	logic advance;
	logic looping;
	logic [PH_W-1:0] leave_ph;

	logic [LVL_W-1:0]     lvl_start;
	logic [PH_W-1:0]      ph_start;
	logic [PAIR_W-1:0]    curve_pair;
	logic [LVL_W-1:0]     curve_lvl;
	logic [LVL_W-1:0]     level_n;
	logic [PH_W-1:0]      phase_n;
	logic [HOLD_BITS-1:0] hold_cnt_n;
	logic [HOLD_BITS-1:0] hold_inc;
	logic                 gate_n;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign phase     = phase_q;

	assign looping  = mode_q[MODE_LOOP];
	assign leave_ph = looping ? PH_RELEASE : PH_DECAY;
	assign hold_inc = hold_cnt_q + HOLD_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_pair_q  <= '0;
			decay_pair_q   <= '0;
			release_pair_q <= '0;
			freeze_pair_q  <= '0;
			sustain_q      <= '0;
			hold_len_q     <= '0;
			mode_q         <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ATTACK:  attack_pair_q  <= cfg_data[PAIR_W-1:0];
				CFG_DECAY:   decay_pair_q   <= cfg_data[PAIR_W-1:0];
				CFG_RELEASE: release_pair_q <= cfg_data[PAIR_W-1:0];
				CFG_FREEZE:  freeze_pair_q  <= cfg_data[PAIR_W-1:0];
				CFG_SUSTAIN: sustain_q      <= cfg_data[LVL_W-1:0];
				CFG_HOLD:    hold_len_q     <= cfg_data[HOLD_LEN_W-1:0];
				CFG_MODE:    mode_q         <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Gate edge and trigger come first; they pick the starting phase
	// and level for the curve step, and the gate edge also updates gate_n.
	always_comb begin
		ph_start  = phase_q;
		lvl_start = level_q;
		gate_n    = gate_seen_q;
		if (tick_s1.hold_gate != gate_seen_q) begin
			gate_n = tick_s1.hold_gate;
			if (!tick_s1.hold_gate && phase_q == PH_HOLD && hold_len_q == '0) begin
				ph_start = leave_ph;
			end
		end
		if (tick_s1.trigger) begin
			if (!(mode_q[MODE_NR_ATK] && ph_start == PH_ATTACK) &&
			    !(mode_q[MODE_NR_DCY] && ph_start == PH_DECAY)) begin
				lvl_start = '0;
			end
			ph_start = PH_ATTACK;
		end
	end

	always_comb begin
		case (ph_start)
			PH_ATTACK:  curve_pair = attack_pair_q;
			PH_DECAY:   curve_pair = tick_s1.freeze_decay ? freeze_pair_q : decay_pair_q;
			PH_RELEASE: curve_pair = release_pair_q;
			default:    curve_pair = attack_pair_q;
		endcase
	end

	adsr_curve u_curve (
		.pair      (curve_pair),
		.level_in  (lvl_start),
		.level_out (curve_lvl)
	);

	always_comb begin
		level_n    = lvl_start;
		phase_n    = ph_start;
		hold_cnt_n = hold_cnt_q;
		case (ph_start)
			PH_HOLD: begin
				if (!gate_n) begin
					hold_cnt_n = hold_inc;
					if (CMP_W'(hold_inc) >= CMP_W'(hold_len_q)) begin
						hold_cnt_n = '0;
						phase_n    = leave_ph;
					end
				end
			end
			PH_IDLE: begin
				if (looping) begin
					phase_n = PH_ATTACK;
				end
			end
			PH_ATTACK: begin
				level_n = curve_lvl;
				if (curve_lvl == LVL_MAX) begin
					if (gate_n || hold_len_q != '0) begin
						phase_n    = PH_HOLD;
						hold_cnt_n = '0;
					end else begin
						phase_n = leave_ph;
					end
				end
			end
			PH_DECAY: begin
				if (!tick_s1.freeze_decay) begin
					level_n = curve_lvl;
					if (curve_lvl <= sustain_q) begin
						level_n = sustain_q;
						phase_n = PH_SUSTAIN;
					end
				end else if (lvl_start > FREEZE_FLOOR && lvl_start < LVL_MAX) begin
					level_n = curve_lvl;
				end
			end
			PH_RELEASE: begin
				level_n = curve_lvl;
				if (curve_lvl == '0) begin
					phase_n = looping ? PH_ATTACK : PH_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tick_s1 <= '{trigger: trigger, hold_gate: hold_gate, freeze_decay: freeze_decay};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			phase_q     <= PH_IDLE;
			hold_cnt_q  <= '0;
			gate_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				level_q     <= level_n;
				phase_q     <= phase_n;
				hold_cnt_q  <= hold_cnt_n;
				gate_seen_q <= gate_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
